@@ rtl/pqs_pkg.sv @@
// ----------------------------------------------------------------------------
// pqs_pkg: shared types for the positional queue with search
// Request and response structs, function and status codes, cell controls.
// ----------------------------------------------------------------------------
package pqs_pkg;

  // Request function codes
  typedef enum logic [1:0] {
    FN_APPEND = 2'd0,
    FN_POP    = 2'd1,
    FN_INSERT = 2'd2,
    FN_SEARCH = 2'd3
  } func_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  localparam int unsigned FIELD_W = 16;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned COUNT_W = 5;

  typedef struct packed {
    func_t              func;
    logic [FIELD_W-1:0] data_x;
    logic [FIELD_W-1:0] data_y;
    logic [POS_W-1:0]   position;
  } req_t;

  typedef struct packed {
    logic [FIELD_W-1:0] out_x;
    logic [FIELD_W-1:0] out_y;
    logic               found;
    status_t            status;
    logic [COUNT_W-1:0] count;
  } rsp_t;

  // Broadcast controls to every cell, valid for one cycle per request
  typedef struct packed {
    logic load;  // a request is taken this cycle
    logic ins;   // open a hole at the insert position and write the key
    logic pop;   // shift every entry one place toward the head
    logic srch;  // compare the key against every live entry
  } cell_ctl_t;

endpackage

@@ rtl/pqs_cell.sv @@
// ----------------------------------------------------------------------------
// pqs_cell: one slot of the shifting queue
// Holds one pair; takes from its left neighbor, its right neighbor or the key,
// and registers a match flag on search.
// ----------------------------------------------------------------------------
module pqs_cell
  import pqs_pkg::*;
#(
  parameter int unsigned IDX    = 0,
  parameter int unsigned DATA_W = 32,
  parameter int unsigned CNT_W  = 5
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [CNT_W-1:0]  ins_pos,
  input  logic [CNT_W-1:0]  count,
  input  logic [DATA_W-1:0] key,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic              match
);

  localparam logic [CNT_W-1:0] MY_IDX = CNT_W'(IDX);

  logic [DATA_W-1:0] data_next;
  logic              hit;

  // Select the next content of this slot
  always_comb begin
    data_next = data;
    if (ctl.ins) begin
      if (MY_IDX == ins_pos) begin
        data_next = key;
      end else if (MY_IDX > ins_pos && MY_IDX <= count) begin
        data_next = left_data;
      end
    end else if (ctl.pop) begin
      data_next = right_data;
    end
  end

  assign hit = (MY_IDX < count) && (data == key);

  always_ff @(posedge clk) begin
    data <= data_next;
    if (ctl.load) begin
      match <= ctl.srch && hit;
    end
  end

endmodule

@@ rtl/positional_queue_with_search.sv @@
// ----------------------------------------------------------------------------
// positional_queue_with_search: ordered pair queue with insert and search
// Append, pop, positional insert and search over a row of shifting cells.
// ----------------------------------------------------------------------------
// One request is taken per clock unless a stalled response blocks the middle
// stage; all cells shift, load or compare in the cycle the request is taken,
// the per-cell match flags are combined as the middle stage moves on, and the
// response is presented from an output register. Requests may follow each
// other back to back; the pipeline runs through cell row, match combine and
// output register, and a stalled response holds at most one further request.
module positional_queue_with_search
  import pqs_pkg::*;
#(
  parameter int unsigned DEPTH   = 16,
  parameter int unsigned COORD_W = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int unsigned DATA_W = 2 * COORD_W;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned PW     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Queue state and cell row
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic [DATA_W-1:0] cell_data [DEPTH];
  logic [DEPTH-1:0]  cell_match;
  logic [DATA_W-1:0] key;
  logic [CNT_W-1:0]  ins_pos;
  cell_ctl_t         ctl;

  // Middle stage and output register
  logic               mid_valid;
  logic               mid_move;
  logic               mid_srch;
  logic [FIELD_W-1:0] mid_x;
  logic [FIELD_W-1:0] mid_y;
  status_t            mid_status;
  logic [COUNT_W-1:0] mid_count;

  // Decode
  logic             take;
  logic             full;
  logic             empty;
  logic             range_err;
  logic [PW-1:0]    pos_w;
  logic [PW-1:0]    cnt_w;
  status_t          status_next;
  logic [COORD_W-1:0] head_x;
  logic [COORD_W-1:0] head_y;

  assign key = {COORD_W'(req.data_y), COORD_W'(req.data_x)};
  assign take = req_valid && req_ready;
  assign full = (count == FULL_CNT);
  assign empty = (count == '0);
  assign pos_w = PW'(req.position);
  assign cnt_w = PW'(count);
  assign range_err = empty ? (pos_w != '0) : (pos_w >= cnt_w);
  assign head_x = cell_data[0][COORD_W-1:0];
  assign head_y = cell_data[0][DATA_W-1:COORD_W];

  // Request decode: status, next count and cell controls
  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    ctl         = '0;
    ctl.load    = take;
    ins_pos     = count;
    case (req.func)
      FN_APPEND: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = take;
          count_next = count + CNT_W'(1);
        end
      end
      FN_POP: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          ctl.pop    = take;
          count_next = count - CNT_W'(1);
        end
      end
      FN_INSERT: begin
        ins_pos = CNT_W'(pos_w);
        if (range_err) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          ctl.ins    = take;
          count_next = count + CNT_W'(1);
        end
      end
      FN_SEARCH: begin
        ctl.srch = take;
      end
      default: begin
        status_next = ST_OK;
      end
    endcase
  end

  // Cell row
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] left_in;
    logic [DATA_W-1:0] right_in;
    if (i == 0) begin : g_head
      assign left_in = '0;
    end else begin : g_left
      assign left_in = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right_in = '0;
    end else begin : g_right
      assign right_in = cell_data[i+1];
    end
    pqs_cell #(
      .IDX    (i),
      .DATA_W (DATA_W),
      .CNT_W  (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .ins_pos    (ins_pos),
      .count      (count),
      .key        (key),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .match      (cell_match[i])
    );
  end

  // Handshake
  assign mid_move  = mid_valid && (!rsp_valid || rsp_ready);
  assign req_ready = !mid_valid || mid_move;

  // Count, middle stage and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      mid_valid <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        count <= count_next;
      end
      if (take) begin
        mid_valid <= 1'b1;
      end else if (mid_move) begin
        mid_valid <= 1'b0;
      end
      if (mid_move) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
    if (take) begin
      mid_srch   <= ctl.srch;
      mid_status <= status_next;
      mid_count  <= COUNT_W'(count_next);
      mid_x      <= ctl.pop ? FIELD_W'(head_x) : '0;
      mid_y      <= ctl.pop ? FIELD_W'(head_y) : '0;
    end
    if (mid_move) begin
      rsp.out_x  <= mid_x;
      rsp.out_y  <= mid_y;
      rsp.found  <= mid_srch && (|cell_match);
      rsp.status <= mid_status;
      rsp.count  <= mid_count;
    end
  end

endmodule

@@ verif/positional_queue_with_search_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// positional_queue_with_search_tb: self-checking bench for the pair queue
// Sends append, pop, insert and search requests with random gaps on both
// channels and predicts every reply from a shadow list of stored pairs.
// ----------------------------------------------------------------------------
module positional_queue_with_search_tb;
  import pqs_pkg::*;

  localparam int unsigned QDEPTH        = 16;
  localparam int unsigned STALL_LIMIT   = 2000;  // cycles with no handshake
  localparam int unsigned N_RANDOM      = 1150;
  localparam int unsigned CALM_TAIL     = 100;   // last requests sent gap-free
  localparam int unsigned DRAIN_SPACING = 250;

  typedef struct {
    req_t r;
    bit   drain;  // hold this request until every reply is back
  } send_item_t;

  logic clk       = 1'b0;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  send_item_t  reqs_to_send[$];
  rsp_t        replies_due[$];
  logic [31:0] pair_list[$];   // {y, x}, index 0 is the head

  bit          req_fire;
  int unsigned req_gap;
  int unsigned rsp_gap;
  int unsigned quiet_cycles;
  int unsigned n_fail;
  send_item_t  next_item;
  rsp_t        want;

  positional_queue_with_search #(
    .DEPTH   (QDEPTH),
    .COORD_W (FIELD_W)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Apply one request to the shadow list and return the reply it earns
  function automatic rsp_t next_queue_reply(req_t r);
    rsp_t        res;
    logic [31:0] key;
    int          n;
    res        = '0;
    res.status = ST_OK;
    key        = {r.data_y, r.data_x};
    n          = pair_list.size();
    case (r.func)
      FN_APPEND: begin
        if (n >= QDEPTH) res.status = ST_FULL;
        else pair_list.push_back(key);
      end
      FN_POP: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else begin
          key       = pair_list.pop_front();
          res.out_x = key[15:0];
          res.out_y = key[31:16];
        end
      end
      FN_INSERT: begin
        // position is checked before fullness
        if ((n != 0 && int'(r.position) >= n) || (n == 0 && r.position != 0))
          res.status = ST_RANGE;
        else if (n >= QDEPTH)
          res.status = ST_FULL;
        else
          pair_list.insert(int'(r.position), key);
      end
      default: begin
        foreach (pair_list[i]) if (pair_list[i] == key) res.found = 1'b1;
      end
    endcase
    res.count = COUNT_W'(pair_list.size());
    return res;
  endfunction

  function automatic bit in_calm_tail();
    return reqs_to_send.size() < CALM_TAIL;
  endfunction

  // Mostly a small pool so searches hit, sometimes any value
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 8))
      0:       return 16'h0000;
      1:       return 16'hffff;
      2:       return 16'h0001;
      3:       return 16'h8000;
      4:       return 16'h5a5a;
      5:       return 16'ha5a5;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic add_req(func_t f, logic [15:0] x, logic [15:0] y,
                         logic [3:0] p, bit drain);
    send_item_t it;
    it.r.func     = f;
    it.r.data_x   = x;
    it.r.data_y   = y;
    it.r.position = p;
    it.drain      = drain;
    reqs_to_send.push_back(it);
  endtask

  task automatic check_field(string name, logic [15:0] exp_v, logic [15:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected %h, actual %h", name, exp_v, act_v);
      n_fail++;
    end
  endtask

  // Request driver: holds a request until taken, then gaps or sends the next
  always @(negedge clk) begin
    if (!rst && !(req_valid && !req_fire)) begin
      if (req_gap > 0) begin
        req_gap--;
        req_valid <= 1'b0;
      end else if (reqs_to_send.size() != 0 &&
                   !(reqs_to_send[0].drain && replies_due.size() != 0)) begin
        next_item = reqs_to_send.pop_front();
        req       <= next_item.r;
        req_valid <= 1'b1;
        if (!in_calm_tail() && $urandom_range(0, 5) == 0)
          req_gap = $urandom_range(1, 14);
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // Reply backpressure in random bursts
  always @(negedge clk) begin
    if (rsp_gap > 0) begin
      rsp_gap--;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= 1'b1;
      if (!in_calm_tail() && $urandom_range(0, 7) == 0)
        rsp_gap = $urandom_range(1, 14);
    end
  end

  // Monitor: check replies, predict accepted requests, watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      req_fire     = 1'b0;
      quiet_cycles = 0;
    end else begin
      req_fire = req_valid && req_ready;
      if (rsp_valid && rsp_ready) begin
        if (replies_due.size() == 0) begin
          $error("reply with none expected: %p", rsp);
          n_fail++;
        end else begin
          want = replies_due.pop_front();
          check_field("out_x", want.out_x, rsp.out_x);
          check_field("out_y", want.out_y, rsp.out_y);
          check_field("found", 16'(want.found), 16'(rsp.found));
          check_field("status", 16'(want.status), 16'(rsp.status));
          check_field("count", 16'(want.count), 16'(rsp.count));
        end
      end
      if (req_fire) replies_due.push_back(next_queue_reply(req));
      if (req_fire || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  // Stimulus, reset and end of run
  initial begin : stim
    int unsigned w;
    func_t       f;
    logic [3:0]  p;

    // Directed: empty cases, fill to full, full cases, range at the end
    add_req(FN_POP,    16'h1111, 16'h2222, 4'd0,  1'b0);
    add_req(FN_INSERT, 16'h3333, 16'h4444, 4'd3,  1'b0);
    add_req(FN_SEARCH, 16'h0000, 16'h0000, 4'd0,  1'b0);
    add_req(FN_INSERT, 16'h0000, 16'h0000, 4'd0,  1'b0);
    add_req(FN_APPEND, 16'hffff, 16'hffff, 4'hf,  1'b0);
    add_req(FN_SEARCH, 16'hffff, 16'h0000, 4'd0,  1'b0);
    for (int i = 0; i < 14; i++)
      add_req(FN_APPEND, 16'(16'h0100 + i), 16'(16'hfe00 - i), 4'(i), 1'b0);
    add_req(FN_APPEND, 16'haaaa, 16'h5555, 4'd0,  1'b1);
    add_req(FN_INSERT, 16'h1234, 16'h5678, 4'hf,  1'b0);
    add_req(FN_INSERT, 16'h1234, 16'h5678, 4'd0,  1'b0);
    add_req(FN_SEARCH, 16'hffff, 16'hffff, 4'd0,  1'b0);
    add_req(FN_POP,    16'h0000, 16'h0000, 4'd0,  1'b0);
    add_req(FN_POP,    16'h0000, 16'h0000, 4'd0,  1'b0);
    add_req(FN_INSERT, 16'h7777, 16'h8888, 4'd14, 1'b0);

    // Random: phases lean toward filling, draining or mixed traffic
    for (int i = 0; i < N_RANDOM; i++) begin
      w = $urandom_range(0, 99);
      case ((i / 60) % 3)
        0:       f = (w < 45) ? FN_APPEND : (w < 70) ? FN_INSERT :
                     (w < 85) ? FN_SEARCH : FN_POP;
        1:       f = (w < 45) ? FN_POP : (w < 60) ? FN_APPEND :
                     (w < 75) ? FN_INSERT : FN_SEARCH;
        default: f = (w < 25) ? FN_APPEND : (w < 50) ? FN_POP :
                     (w < 65) ? FN_INSERT : FN_SEARCH;
      endcase
      p = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 15))
                                      : 4'($urandom_range(0, 3));
      add_req(f, pick_coord(), pick_coord(), p, (i % DRAIN_SPACING) == DRAIN_SPACING - 1);
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    @(posedge clk);
    while (reqs_to_send.size() != 0 || req_valid) @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (n_fail == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
